// ===== rtl/core/ptc_pkg.sv =====
// ============================================================================
// ptc_pkg
// Shared types, register codes and helpers for the pixel tint colorize core.
// ============================================================================
`default_nettype none

package ptc_pkg;

    localparam int PTC_CHANNEL_BITS = 8;
    localparam int PTC_AW           = 4;   // byte address, three 32-bit registers
    localparam int PTC_PIPE_LAT     = 8;   // accept edge to result edge
    localparam int PTC_WGT_BITS     = 17;  // blend weights, 0..65536

    // register codes (word index = paddr[3:2])
    localparam logic [1:0] PTC_REG_HUE   = 2'd0;
    localparam logic [1:0] PTC_REG_SAT   = 2'd1;
    localparam logic [1:0] PTC_REG_SHIFT = 2'd2;

    localparam logic [8:0] PTC_HUE_RST   = 9'd0;
    localparam logic [6:0] PTC_SAT_RST   = 7'd0;
    localparam logic [7:0] PTC_SHIFT_RST = 8'd41;
    localparam logic [6:0] PTC_PCT_FULL  = 7'd100;

    typedef enum logic [1:0] {
        TINT_IDLE,
        TINT_PREP,
        TINT_MUL,
        TINT_FIX
    } t_ptc_tint_state;

    typedef struct packed {
        logic valid;
        logic frc_zero;   // shift at or below -100: black
        logic frc_full;   // shift at or above +100: white
    } t_ptc_ctl;

    // hue ramp: rises 0..60, flat to 180, falls to 240, zero above
    function automatic logic [5:0] ptc_ramp(input logic [8:0] ang);
        logic [8:0] down;
        down = 9'd240 - ang;
        if (ang < 9'd60) begin
            ptc_ramp = ang[5:0];
        end else if (ang < 9'd180) begin
            ptc_ramp = 6'd60;
        end else if (ang < 9'd240) begin
            ptc_ramp = down[5:0];
        end else begin
            ptc_ramp = 6'd0;
        end
    endfunction

    // modulo 360 for angles below 720
    function automatic logic [8:0] ptc_wrap360(input logic [9:0] ang);
        logic [9:0] sub;
        sub = ang - 10'd360;
        ptc_wrap360 = (ang >= 10'd360) ? sub[8:0] : ang[8:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pixel_tint_colorize_core.sv =====
// ============================================================================
// pixel_tint_colorize_core
// RGBA colorize: tint from hue/saturation, lightness-driven black/tint/white.
// ============================================================================
// Accept: a word is taken on the edge where start & !busy.
// Throughput: one word per clock while busy is low; the 8-stage datapath never
//   stalls and the receiver cannot hold results off.
// Reset: synchronous, active low; registers go to hue 0, saturation 0,
//   shift 41. busy then stays high while the tint colors are rebuilt
//   (numerator, reciprocal multiply, fix-up); each hue or saturation write
//   repeats that.
`default_nettype none

module pixel_tint_colorize_core import ptc_pkg::*; #(
    parameter int CHANNEL_BITS = PTC_CHANNEL_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  logic [CHANNEL_BITS-1:0]   i_red_in,
    input  logic [CHANNEL_BITS-1:0]   i_green_in,
    input  logic [CHANNEL_BITS-1:0]   i_blue_in,
    input  logic [CHANNEL_BITS-1:0]   i_alpha_in,
    // result channel
    output logic                      o_strobe,
    output logic [CHANNEL_BITS-1:0]   o_red_out,
    output logic [CHANNEL_BITS-1:0]   o_green_out,
    output logic [CHANNEL_BITS-1:0]   o_blue_out,
    output logic [CHANNEL_BITS-1:0]   o_alpha_out,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PTC_AW-1:0]         paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int QW = CHANNEL_BITS + 16;

    // configuration registers
    logic [8:0] r_hue;
    logic [6:0] r_sat;
    logic [7:0] r_shift;

    logic [1:0] reg_idx;
    logic       cfg_wr;
    logic       restart;
    logic       accept;
    logic       tint_busy;

    logic [2:0][QW-1:0]           col;
    t_ptc_ctl                     lp_ctl;
    logic [PTC_WGT_BITS-1:0]      lp_wa, lp_wb;
    logic [CHANNEL_BITS-1:0]      lp_alpha;
    logic [2:0][CHANNEL_BITS-1:0] pix;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    // only hue and saturation feed the tint colors
    assign restart = cfg_wr & ((reg_idx == PTC_REG_HUE) || (reg_idx == PTC_REG_SAT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue   <= PTC_HUE_RST;
            r_sat   <= PTC_SAT_RST;
            r_shift <= PTC_SHIFT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                PTC_REG_HUE:   r_hue   <= pwdata[8:0];
                PTC_REG_SAT:   r_sat   <= pwdata[6:0];
                PTC_REG_SHIFT: r_shift <= pwdata[7:0];
                default: ;     // unmapped word: dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            PTC_REG_HUE:   prdata = {23'd0, r_hue};
            PTC_REG_SAT:   prdata = {25'd0, r_sat};
            PTC_REG_SHIFT: prdata = {24'd0, r_shift};
            default:       prdata = '0;
        endcase
    end

    // input accepted whenever the tint colors are settled
    assign busy   = tint_busy;
    assign accept = start & ~busy;

    // tint colors: rebuilt after reset and after hue/saturation writes
    ptc_tint_unit #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_tint (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_hue     (r_hue),
        .i_sat     (r_sat),
        .o_col     (col),
        .o_busy    (tint_busy)
    );

    // stages 1-6: lightness and shift to blend weights
    ptc_light_pipe #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_light (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_alpha (i_alpha_in),
        .i_shift (r_shift),
        .o_ctl   (lp_ctl),
        .o_wa    (lp_wa),
        .o_wb    (lp_wb),
        .o_alpha (lp_alpha)
    );

    // stages 7-8: per-channel blend, round, clamp, output register
    ptc_blend #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lp_ctl),
        .i_wa    (lp_wa),
        .i_wb    (lp_wb),
        .i_col   (col),
        .i_alpha (lp_alpha),
        .o_valid (o_strobe),
        .o_pix   (pix),
        .o_alpha (o_alpha_out)
    );

    assign o_red_out   = pix[0];
    assign o_green_out = pix[1];
    assign o_blue_out  = pix[2];

    // every accepted word comes out exactly once, a fixed latency later
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##PTC_PIPE_LAT o_strobe)
        else $error("accepted word did not reach the output on time");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, PTC_PIPE_LAT))
        else $error("result strobe without a matching accept");

    // a tint color change must block input until the new colors are ready
    a_tint_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> busy)
        else $error("hue/saturation write did not raise busy");

endmodule

`default_nettype wire

// ===== rtl/core/ptc_tint_unit.sv =====
// ============================================================================
// ptc_tint_unit
// Builds the three Q16 tint channels from hue and saturation in registered steps:
// numerator, multiply by the reciprocal of 375, one-step quotient fix-up.
// ============================================================================
`default_nettype none

module ptc_tint_unit import ptc_pkg::*; #(
    parameter int CHANNEL_BITS = PTC_CHANNEL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_restart,
    input  logic [8:0]                       i_hue,
    input  logic [6:0]                       i_sat,
    output logic [2:0][CHANNEL_BITS+15:0]    o_col,
    output logic                             o_busy
);

    localparam int NW = CHANNEL_BITS + 13;   // numerator, at most M*6000
    localparam int DW = NW + 12;             // numerator * 4096 + 187
    localparam int QW = CHANNEL_BITS + 16;
    localparam int RW = DW - 8;              // floor(2^DW / 375)
    localparam int PW = NW + RW + 12;
    localparam int FW = DW + 1;
    localparam logic [63:0]   RCP64    = (64'd1 << DW) / 64'd375;
    localparam logic [RW-1:0] RCP      = RCP64[RW-1:0];
    localparam logic [PW-1:0] RCP_BIAS = PW'(RCP) * PW'(187);
    localparam logic [FW-1:0] DIVISOR  = FW'(375);
    localparam logic [11:0]   DVD_BIAS = 12'd187;
    localparam logic [6:0]    SIXTY    = 7'd60;

    t_ptc_tint_state r_state, n_state;
    logic            ld, mul, fix;

    logic [NW-1:0]   r_num [3];
    logic [QW-1:0]   r_est [3];
    logic [QW-1:0]   r_quo [3];

    logic [8:0]      hue_w;
    logic [8:0]      ang [3];
    logic [6:0]      sat_c;
    logic [12:0]     gray_w;
    logic [NW-1:0]   numer [3];
    logic [PW-1:0]   prod  [3];
    logic [DW-1:0]   dvd   [3];
    logic            up    [3];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TINT_IDLE: begin
                if (i_restart) n_state = TINT_PREP;
            end
            TINT_PREP: begin
                n_state = i_restart ? TINT_PREP : TINT_MUL;
            end
            TINT_MUL: begin
                n_state = i_restart ? TINT_PREP : TINT_FIX;
            end
            TINT_FIX: begin
                n_state = i_restart ? TINT_PREP : TINT_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != TINT_IDLE);
        ld     = (r_state == TINT_PREP);
        mul    = (r_state == TINT_MUL);
        fix    = (r_state == TINT_FIX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TINT_PREP;
        end else begin
            r_state <= n_state;
        end
    end

    // numerators: M*ramp*sat + G*60*(100-sat)
    always_comb begin
        hue_w  = ptc_wrap360({1'b0, i_hue});
        ang[0] = ptc_wrap360({1'b0, hue_w} + 10'd120);
        ang[1] = hue_w;
        ang[2] = ptc_wrap360({1'b0, hue_w} + 10'd240);
        sat_c  = (i_sat > PTC_PCT_FULL) ? PTC_PCT_FULL : i_sat;
        gray_w = 13'(PTC_PCT_FULL - sat_c) * 13'(SIXTY);
        for (int i = 0; i < 3; i++) begin
            numer[i] = (NW'(13'(ptc_ramp(ang[i])) * 13'(sat_c)) << CHANNEL_BITS)
                     - NW'(13'(ptc_ramp(ang[i])) * 13'(sat_c))
                     + (NW'(gray_w) << (CHANNEL_BITS - 1));
        end
    end

    // quotient estimate is exact or one low; fix-up compares back
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = ((PW'(r_num[i]) * PW'(RCP)) << 12) + RCP_BIAS;
            dvd[i]  = {r_num[i], DVD_BIAS};
            up[i]   = ((FW'(r_est[i]) + FW'(1)) * DIVISOR) <= FW'(dvd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (ld) begin
                r_num[i] <= numer[i];
            end
            if (mul) begin
                r_est[i] <= prod[i][DW+QW-1:DW];
            end
            if (fix) begin
                r_quo[i] <= r_est[i] + QW'(up[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_col[i] = r_quo[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ptc_light_pipe.sv =====
// ============================================================================
// ptc_light_pipe
// Six-stage path from pixel lightness and shift to the two blend weights
// (tint weight a, white weight b, both Q16).
// ============================================================================
`default_nettype none

module ptc_light_pipe import ptc_pkg::*; #(
    parameter int CHANNEL_BITS = PTC_CHANNEL_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [CHANNEL_BITS-1:0]   i_red,
    input  logic [CHANNEL_BITS-1:0]   i_green,
    input  logic [CHANNEL_BITS-1:0]   i_blue,
    input  logic [CHANNEL_BITS-1:0]   i_alpha,
    input  logic [7:0]                i_shift,
    output t_ptc_ctl                  o_ctl,
    output logic [PTC_WGT_BITS-1:0]   o_wa,
    output logic [PTC_WGT_BITS-1:0]   o_wb,
    output logic [CHANNEL_BITS-1:0]   o_alpha
);

    localparam int LW      = CHANNEL_BITS + 1;
    localparam int KW      = CHANNEL_BITS + 8;
    localparam int RW      = 18;
    localparam int PW      = KW + 19;
    localparam int EW      = 18;
    localparam int DNW     = CHANNEL_BITS + 7;
    localparam int MW      = CHANNEL_BITS + 25;
    localparam int DEN_INT = 100 * ((1 << CHANNEL_BITS) - 1);
    localparam logic [LW-1:0]  TWO_MAX  = LW'(2 * ((1 << CHANNEL_BITS) - 1));
    localparam logic [DNW-1:0] DEN      = DNW'(DEN_INT);
    localparam logic [DNW-1:0] HALF_DEN = DNW'(DEN_INT / 2);
    localparam logic [63:0]    RCP64    = (64'd1 << (KW + 16)) / 64'(DEN_INT);
    localparam logic [RW-1:0]  RCP      = RCP64[RW-1:0];
    localparam logic [PW-1:0]  EST_RND  = PW'(1) << (KW - 1);
    localparam logic [EW-1:0]  Q_ONE    = EW'(65536);
    localparam logic [EW-1:0]  Q_TWO    = EW'(131072);

    t_ptc_ctl                r_ctl   [6];
    logic [CHANNEL_BITS-1:0] r_alpha [6];
    logic                    r_neg   [5];

    logic [LW-1:0]  r_s1_l;
    logic [6:0]     r_s1_w;
    logic [KW-1:0]  r_s2_k;
    logic [PW-1:0]  r_s3_p;
    logic [KW-1:0]  r_s3_k;
    logic [MW-1:0]  r_s4_m;
    logic [MW-1:0]  r_s4_y;
    logic [EW-1:0]  r_s4_e;
    logic [EW-1:0]  r_s5_f;
    logic [PTC_WGT_BITS-1:0] r_s6_a, r_s6_b;

    logic [CHANNEL_BITS-1:0] mx, mn;
    logic [LW-1:0]  sum;
    logic [8:0]     sh9, wtmp;
    logic           neg;
    t_ptc_ctl       ctl_in;
    logic           f_up;
    logic [EW-1:0]  s6_a, s6_b;

    // stage 1: max/min, lightness sum, shift weight
    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue  > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue  < mn) mn = i_blue;
        sum  = LW'(mx) + LW'(mn);
        sh9  = {i_shift[7], i_shift};
        neg  = i_shift[7];
        wtmp = neg ? (9'd100 + sh9) : (9'd100 - sh9);
        ctl_in.valid    = i_valid;
        ctl_in.frc_zero = ($signed(i_shift) <= -8'sd100);
        ctl_in.frc_full = ($signed(i_shift) >= 8'sd100);
    end

    // stage 5 correction and stage 6 weights
    always_comb begin
        f_up = ((MW + 1)'(r_s4_m) + (MW + 1)'(DEN)) <= (MW + 1)'(r_s4_y);
        s6_a = (r_s5_f <= Q_ONE) ? r_s5_f : (Q_TWO - r_s5_f);
        if (r_neg[4]) begin
            s6_b = (r_s5_f > Q_ONE) ? (r_s5_f - Q_ONE) : '0;
        end else begin
            s6_b = (r_s5_f < Q_ONE) ? (Q_ONE - r_s5_f) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_ctl[0] <= ctl_in;
            for (int i = 1; i < 6; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha[0] <= i_alpha;
        for (int i = 1; i < 6; i++) begin
            r_alpha[i] <= r_alpha[i-1];
        end
        r_neg[0] <= neg;
        for (int i = 1; i < 5; i++) begin
            r_neg[i] <= r_neg[i-1];
        end
        // stage 1
        r_s1_l <= neg ? sum : (TWO_MAX - sum);
        r_s1_w <= wtmp[6:0];
        // stage 2: k = weight * lightness term
        r_s2_k <= KW'(r_s1_w) * KW'(r_s1_l);
        // stage 3: quotient estimate by reciprocal
        r_s3_p <= PW'(r_s2_k) * PW'(RCP) + EST_RND;
        r_s3_k <= r_s2_k;
        // stage 4: back-multiply estimate, build exact dividend
        r_s4_e <= r_s3_p[KW+EW-1:KW];
        r_s4_m <= MW'(r_s3_p[KW+EW-1:KW]) * MW'(DEN);
        r_s4_y <= MW'({r_s3_k, 16'd0}) + MW'(HALF_DEN);
        // stage 5: estimate is exact or one low
        r_s5_f <= r_s4_e + EW'(f_up);
        // stage 6
        r_s6_a <= s6_a[PTC_WGT_BITS-1:0];
        r_s6_b <= s6_b[PTC_WGT_BITS-1:0];
    end

    assign o_ctl   = r_ctl[5];
    assign o_wa    = r_s6_a;
    assign o_wb    = r_s6_b;
    assign o_alpha = r_alpha[5];

endmodule

`default_nettype wire

// ===== rtl/core/ptc_blend.sv =====
// ============================================================================
// ptc_blend
// Two-stage per-channel blend: tint*a + M*b, round, clamp, force overrides.
// ============================================================================
`default_nettype none

module ptc_blend import ptc_pkg::*; #(
    parameter int CHANNEL_BITS = PTC_CHANNEL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ptc_ctl                         i_ctl,
    input  logic [PTC_WGT_BITS-1:0]          i_wa,
    input  logic [PTC_WGT_BITS-1:0]          i_wb,
    input  logic [2:0][CHANNEL_BITS+15:0]    i_col,
    input  logic [CHANNEL_BITS-1:0]          i_alpha,
    output logic                             o_valid,
    output logic [2:0][CHANNEL_BITS-1:0]     o_pix,
    output logic [CHANNEL_BITS-1:0]          o_alpha
);

    localparam int AW = CHANNEL_BITS + 33;
    localparam int WW = CHANNEL_BITS + 17;
    localparam logic [AW-1:0]           RND   = AW'(1) << 31;
    localparam logic [CHANNEL_BITS:0]   MAXV  = (CHANNEL_BITS + 1)'((1 << CHANNEL_BITS) - 1);

    t_ptc_ctl                r_s7_ctl;
    logic [AW-1:0]           r_pc [3];
    logic [WW-1:0]           r_pw;
    logic [CHANNEL_BITS-1:0] r_s7_alpha;

    logic                    r_valid;
    logic [2:0][CHANNEL_BITS-1:0] r_pix;
    logic [CHANNEL_BITS-1:0] r_alpha;

    logic [AW-1:0]           acc  [3];
    logic [CHANNEL_BITS:0]   val  [3];
    logic [2:0][CHANNEL_BITS-1:0] pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = r_pc[i] + AW'({r_pw, 16'd0}) + RND;
            val[i] = acc[i][AW-1:32];
            if (r_s7_ctl.frc_zero) begin
                pix[i] = '0;
            end else if (r_s7_ctl.frc_full || (val[i] > MAXV)) begin
                pix[i] = MAXV[CHANNEL_BITS-1:0];
            end else begin
                pix[i] = val[i][CHANNEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_ctl <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_s7_ctl <= i_ctl;
            r_valid  <= r_s7_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pc[i] <= AW'(i_col[i]) * AW'(i_wa);
        end
        r_pw       <= (WW'(i_wb) << CHANNEL_BITS) - WW'(i_wb);
        r_s7_alpha <= i_alpha;
        r_pix      <= pix;
        r_alpha    <= r_s7_alpha;
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_alpha = r_alpha;

endmodule

`default_nettype wire

// ===== dv/tb_pixel_tint_colorize_core.sv =====
// ============================================================================
// tb_pixel_tint_colorize_core
// Self-checking bench for the RGBA colorize core. Each pixel word accepted
// on the command channel is run through a local fixed-point predictor and
// queued. Every strobed result is checked field by field against the oldest
// queued word. Tint and shift registers are reprogrammed over the APB port
// only while the pipe is empty.
// ============================================================================
`default_nettype none

module tb_pixel_tint_colorize_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    localparam int          CHW           = PTC_CHANNEL_BITS;
    localparam int unsigned CH_MAX        = (1 << CHW) - 1;
    localparam int unsigned CH_MID        = 1 << (CHW - 1);
    localparam logic [1:0]  REG_UNUSED    = 2'd3;           // decodes to nothing
    localparam int          DRAIN_CYCLES  = PTC_PIPE_LAT + 4;
    localparam int          CYCLE_LIMIT   = 100000;
    localparam int          RANDOM_PHASES = 16;
    localparam int          PHASE_PIXELS  = 24;

    typedef struct packed {
        logic [CHW-1:0] red;
        logic [CHW-1:0] green;
        logic [CHW-1:0] blue;
        logic [CHW-1:0] alpha;
    } t_pixel;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [CHW-1:0]  i_red_in;
    logic [CHW-1:0]  i_green_in;
    logic [CHW-1:0]  i_blue_in;
    logic [CHW-1:0]  i_alpha_in;
    logic            o_strobe;
    logic [CHW-1:0]  o_red_out;
    logic [CHW-1:0]  o_green_out;
    logic [CHW-1:0]  o_blue_out;
    logic [CHW-1:0]  o_alpha_out;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [PTC_AW-1:0] paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    // ------------------------------------------------------------------------
    // Bench state: shadow copy of the registers, words in flight, tallies
    // ------------------------------------------------------------------------
    logic [8:0]  cfg_hue   = PTC_HUE_RST;
    logic [6:0]  cfg_sat   = PTC_SAT_RST;
    logic [7:0]  cfg_shift = PTC_SHIFT_RST;

    t_pixel      colorized_due[$];     // predicted words not yet strobed out
    bit          burst_mode;           // no gaps between command words
    int          fail_cnt;
    int          pixels_sent;
    int          results_seen;
    int          reg_writes;
    int          cycle_cnt;

    always #2 i_clk = ~i_clk;          // 4 ns period

    pixel_tint_colorize_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_alpha_in  (i_alpha_in),
        .o_strobe    (o_strobe),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Hue ramp in degrees: up 0..60, flat to 180, down to 240, zero after.
    function automatic int unsigned ramp_deg(input int unsigned ang);
        if (ang < 60) return ang;
        if (ang < 180) return 60;
        if (ang < 240) return 240 - ang;
        return 0;
    endfunction

    // Tint level of one channel in Q16: pure hue mixed from mid gray by sat.
    function automatic longint unsigned tint_level_q16(input int unsigned ang,
                                                       input int unsigned sat);
        longint unsigned m;
        longint unsigned g;
        longint unsigned numer;
        m = CH_MAX;
        g = CH_MID;
        numer = m * ramp_deg(ang) * sat + g * 60 * (100 - sat);
        return (numer * 65536 + 3000) / 6000;
    endfunction

    // Negative position: black toward tint. Positive: tint toward white.
    function automatic logic [CHW-1:0] blend_level(input longint unsigned col_q,
                                                   input longint pos_q);
        longint unsigned m;
        longint unsigned acc;
        m = CH_MAX;
        if (pos_q <= 0) begin
            acc = col_q * longint'(pos_q + 65536);
        end else begin
            acc = col_q * longint'(65536 - pos_q) + m * 65536 * longint'(pos_q);
        end
        acc = (acc + (64'd1 << 31)) >> 32;
        if (acc > m) acc = m;
        return acc[CHW-1:0];
    endfunction

    function automatic t_pixel colorize_pixel(input t_pixel px);
        int unsigned     mx;
        int unsigned     mn;
        int unsigned     hue;
        int unsigned     sat;
        int              sh;
        longint unsigned den;
        longint unsigned k;
        longint unsigned f;
        longint          pos_q;
        t_pixel          res;
        mx = px.red;
        mn = px.red;
        if (px.green > mx) mx = px.green;
        if (px.blue > mx) mx = px.blue;
        if (px.green < mn) mn = px.green;
        if (px.blue < mn) mn = px.blue;
        hue = cfg_hue;
        if (hue >= 360) hue -= 360;                 // 360..511 wraps
        sat = (cfg_sat > PTC_PCT_FULL) ? 100 : cfg_sat;
        sh  = $signed(cfg_shift);
        res.alpha = px.alpha;
        if (sh <= -100) begin
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
        end else if (sh >= 100) begin
            res.red   = '1;
            res.green = '1;
            res.blue  = '1;
        end else begin
            den = 100 * CH_MAX;
            if (sh >= 0) begin
                k = longint'(100 - sh) * (2 * CH_MAX - mx - mn);
                f = (k * 65536 + den / 2) / den;
                pos_q = 65536 - longint'(f);
            end else begin
                k = longint'(100 + sh) * (mx + mn);
                f = (k * 65536 + den / 2) / den;
                pos_q = longint'(f) - 65536;
            end
            res.red   = blend_level(tint_level_q16((hue + 120) % 360, sat), pos_q);
            res.green = blend_level(tint_level_q16(hue, sat), pos_q);
            res.blue  = blend_level(tint_level_q16((hue + 240) % 360, sat), pos_q);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every strobe must match the oldest predicted word.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [CHW-1:0] want,
                                        input logic [CHW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (colorized_due.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h %h %h %h",
                         $time, o_red_out, o_green_out, o_blue_out, o_alpha_out);
                fail_cnt++;
            end else begin
                want = colorized_due.pop_front();
                check_field("red", want.red, o_red_out);
                check_field("green", want.green, o_green_out);
                check_field("blue", want.blue, o_blue_out);
                check_field("alpha", want.alpha, o_alpha_out);
                results_seen++;
            end
        end
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("pixel_tint_colorize_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one pixel word. start stays high afterwards so back-to-back words
    // go out every cycle while busy is low; a gap or settle_idle drops it.
    task automatic push_pixel(input t_pixel px);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        i_alpha_in <= px.alpha;
        do @(posedge i_clk); while (busy !== 1'b0);
        colorized_due.push_back(colorize_pixel(px));
        pixels_sent++;
    endtask

    // Wait for the pipe to empty before touching registers.
    task automatic settle_idle();
        start <= 1'b0;
        while (colorized_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] code, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (code)
            PTC_REG_HUE:   cfg_hue   = value[8:0];
            PTC_REG_SAT:   cfg_sat   = value[6:0];
            PTC_REG_SHIFT: cfg_shift = value[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_tint(input int unsigned hue, input int unsigned sat,
                            input logic [7:0] shift);
        settle_idle();
        write_reg(PTC_REG_HUE, 32'(hue));
        write_reg(PTC_REG_SAT, 32'(sat));
        write_reg(PTC_REG_SHIFT, {24'd0, shift});
    endtask

    function automatic t_pixel rgba(input int r, input int g, input int b, input int a);
        t_pixel px;
        px.red   = r[CHW-1:0];
        px.green = g[CHW-1:0];
        px.blue  = b[CHW-1:0];
        px.alpha = a[CHW-1:0];
        return px;
    endfunction

    // Mostly uniform pixels, plus grays, saturated corners and near-grays.
    function automatic t_pixel random_pixel();
        t_pixel px;
        px.red   = CHW'($urandom_range(0, CH_MAX));
        px.green = CHW'($urandom_range(0, CH_MAX));
        px.blue  = CHW'($urandom_range(0, CH_MAX));
        px.alpha = CHW'($urandom_range(0, CH_MAX));
        case ($urandom_range(0, 9))
            6: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            7: begin
                px.red   = $urandom_range(0, 1) ? '1 : '0;
                px.green = $urandom_range(0, 1) ? '1 : '0;
                px.blue  = $urandom_range(0, 1) ? '1 : '0;
            end
            8: begin
                px.green = px.red ^ CHW'(1);
                px.blue  = px.red;
            end
            default: ;
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values (hue 0, sat 0, shift 41) on channel extremes.
    task automatic test_corner_pixels();
        push_pixel(rgba(0, 0, 0, 0));
        push_pixel(rgba(255, 255, 255, 255));
        push_pixel(rgba(255, 0, 0, 8'h55));
        push_pixel(rgba(0, 255, 0, 8'hAA));
        push_pixel(rgba(0, 0, 255, 8'h80));
        push_pixel(rgba(128, 127, 128, 8'h7F));
        push_pixel(rgba(1, 254, 0, 8'h01));
        push_pixel(rgba(255, 255, 0, 8'hFE));
    endtask

    // Shift at or past the limits forces black or white; alpha still copied.
    task automatic test_forced_shift();
        set_tint(200, 60, 8'h80);                 // -128
        push_pixel(rgba(255, 255, 255, 8'h12));
        push_pixel(rgba(37, 190, 4, 8'hED));
        settle_idle();
        write_reg(PTC_REG_SHIFT, 32'h0000_009C); // -100
        push_pixel(rgba(255, 200, 100, 8'h33));
        settle_idle();
        write_reg(PTC_REG_SHIFT, 32'h0000_0064); // +100
        push_pixel(rgba(0, 0, 0, 8'hCC));
        settle_idle();
        write_reg(PTC_REG_SHIFT, 32'h0000_007F); // +127
        push_pixel(rgba(0, 0, 0, 8'h00));
        push_pixel(rgba(90, 10, 250, 8'hFF));
    endtask

    // Hue past 359 wraps, saturation past 100 is full, shift one step in.
    task automatic test_wrap_and_clamp();
        set_tint(511, 127, 8'h9D);               // hue 151, sat 100, shift -99
        push_pixel(rgba(255, 255, 255, 8'h5A));
        push_pixel(rgba(0, 128, 255, 8'hA5));
        push_pixel(rgba(64, 64, 64, 8'h3C));
        set_tint(360, 100, 8'd99);
        push_pixel(rgba(0, 0, 0, 8'hC3));
        push_pixel(rgba(200, 30, 120, 8'h0F));
        set_tint(359, 0, 8'd0);
        push_pixel(rgba(10, 250, 130, 8'hF0));
        push_pixel(rgba(255, 0, 255, 8'h69));
    endtask

    // Write to the unmapped slot must not disturb any register.
    task automatic test_unused_register();
        settle_idle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        push_pixel(rgba(77, 150, 222, 8'h96));
        push_pixel(rgba(255, 1, 128, 8'h81));
    endtask

    // Random settings, each followed by a run of random pixels; some phases
    // stream back to back, the rest with random gaps.
    task automatic test_random_phases();
        int unsigned hue;
        int unsigned sat;
        int          shift;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            hue = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
                                              : $urandom_range(0, 359);
            case ($urandom_range(0, 7))
                0:       sat = $urandom_range(101, 127);
                1:       sat = $urandom_range(0, 1) ? 100 : 0;
                default: sat = $urandom_range(0, 100);
            endcase
            case ($urandom_range(0, 9))
                0:       shift = $urandom_range(0, 255);   // any byte, forced too
                1:       shift = $urandom_range(0, 1) ? 99 : -99;
                default: shift = int'($urandom_range(0, 198)) - 99;
            endcase
            set_tint(hue, sat, shift[7:0]);
            burst_mode = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                push_pixel(random_pixel());
            end
            burst_mode = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        start      <= 1'b0;
        i_red_in   <= '0;
        i_green_in <= '0;
        i_blue_in  <= '0;
        i_alpha_in <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_rst_n    <= 1'b0;
        burst_mode  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n    <= 1'b1;

        test_corner_pixels();
        test_forced_shift();
        test_wrap_and_clamp();
        test_unused_register();
        test_random_phases();
        settle_idle();

        $display("Checked %0d of %0d pixel words across %0d register writes,", results_seen,
                 pixels_sent, reg_writes);
        $display("covering forced black/white, hue wrap, sat clamp and random tints.");
        if (fail_cnt == 0) begin
            $display("pixel_tint_colorize_core test passed");
        end else begin
            $display("pixel_tint_colorize_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
